// ===== rtl/core/rgb_led_effect_sequencer_top_macros.svh =====
// Assertion macros shared by the RGB LED effect sequencer modules.
`ifndef RGB_LED_EFFECT_SEQUENCER_TOP_MACROS_SVH
`define RGB_LED_EFFECT_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define RGBLES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define RGBLES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rgbles_pkg.sv =====
// Types, constants and helpers shared by the RGB LED effect sequencer.
package rgbles_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 5;

    localparam logic [31:0] STROBE_TICKS = 32'd100;
    localparam logic [31:0] FLASH_TICKS  = 32'd500;
    localparam logic [31:0] FADE_TICKS   = 32'd10;
    localparam logic [31:0] FLASH_EXTRA  = 32'd600;
    localparam logic [31:0] FADE_EXTRA   = 32'd200;
    localparam logic [1:0]  FLASH_LEN    = 2'd3;
    localparam logic [2:0]  FADE_PHASES  = 3'd6;
    localparam logic [8:0]  FADE_TOP     = 9'd256;
    localparam logic [7:0]  LEVEL_MAX    = 8'hFF;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STROBE = 2'd1,
        MODE_FLASH  = 2'd2,
        MODE_FADE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_ENABLE       = 3'd0,
        REG_COMMON_ANODE = 3'd1,
        REG_EFFECT_MODE  = 3'd2,
        REG_BASE_COLOR   = 3'd3,
        REG_SPEED        = 3'd4,
        REG_FLASH_A      = 3'd5,
        REG_FLASH_B      = 3'd6,
        REG_FLASH_C      = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        CHAN_RED   = 2'd0,
        CHAN_GREEN = 2'd1,
        CHAN_BLUE  = 2'd2
    } chan_t;

    // Red in the top byte, as in the colour registers.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic        enable;
        logic        common_anode;
        mode_t       effect_mode;
        logic [23:0] base_color;
        logic [10:0] speed;
        logic [23:0] flash_a;
        logic [23:0] flash_b;
        logic [23:0] flash_c;
    } cfg_t;

    typedef struct packed {
        rgb_t levels;
        logic fired;
    } step_res_t;

    // Colour as driven on the pins; common anode wiring needs 255 - value.
    function automatic rgb_t show_rgb(input logic [23:0] color, input logic anode);
        return rgb_t'(anode ? ~color : color);
    endfunction

endpackage

// ===== rtl/core/rgbles_cfg.sv =====
// APB register file holding the sequencer configuration.
module rgbles_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbles_pkg::ADDR_W-1:0]   paddr,
    input  logic [rgbles_pkg::DATA_W-1:0]   pwdata,
    output logic [rgbles_pkg::DATA_W-1:0]   prdata,
    output logic                            pready,
    output rgbles_pkg::cfg_t                cfg,
    output logic                            mode_clear
);
    import rgbles_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.common_anode <= 1'b0;
            cfg_reg.effect_mode  <= MODE_NORMAL;
            cfg_reg.base_color   <= 24'h000000;
            cfg_reg.speed        <= 11'd0;
            cfg_reg.flash_a      <= 24'hFF0000;
            cfg_reg.flash_b      <= 24'h00FF00;
            cfg_reg.flash_c      <= 24'h0000FF;
            mode_clear           <= 1'b0;
        end
        else
        begin
            mode_clear <= 1'b0;
            if (wr_en)
            begin
                case (idx)
                    REG_ENABLE:       cfg_reg.enable       <= pwdata[0];
                    REG_COMMON_ANODE: cfg_reg.common_anode <= pwdata[0];
                    REG_EFFECT_MODE:
                    begin
                        cfg_reg.effect_mode <= mode_t'(pwdata[1:0]);
                        mode_clear          <= 1'b1;
                    end
                    REG_BASE_COLOR:   cfg_reg.base_color   <= pwdata[23:0];
                    REG_SPEED:        cfg_reg.speed        <= pwdata[10:0];
                    REG_FLASH_A:      cfg_reg.flash_a      <= pwdata[23:0];
                    REG_FLASH_B:      cfg_reg.flash_b      <= pwdata[23:0];
                    REG_FLASH_C:      cfg_reg.flash_c      <= pwdata[23:0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_ENABLE:       prdata = {31'd0, cfg_reg.enable};
            REG_COMMON_ANODE: prdata = {31'd0, cfg_reg.common_anode};
            REG_EFFECT_MODE:  prdata = {30'd0, cfg_reg.effect_mode};
            REG_BASE_COLOR:   prdata = {8'd0, cfg_reg.base_color};
            REG_SPEED:        prdata = {21'd0, cfg_reg.speed};
            REG_FLASH_A:      prdata = {8'd0, cfg_reg.flash_a};
            REG_FLASH_B:      prdata = {8'd0, cfg_reg.flash_b};
            REG_FLASH_C:      prdata = {8'd0, cfg_reg.flash_c};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/rgbles_step.sv =====
// Sequence state and the combinational effect step for one tick.
`include "rgb_led_effect_sequencer_top_macros.svh"

module rgbles_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rgbles_pkg::cfg_t      cfg,
    input  logic                  mode_clear,
    input  logic                  step_en,
    input  logic [31:0]           now,
    output rgbles_pkg::step_res_t res
);
    import rgbles_pkg::*;

    logic [31:0] last_event_reg, last_event_next;
    logic        strobe_phase_reg, strobe_phase_next;
    logic [1:0]  flash_index_reg, flash_index_next;
    logic [2:0]  fade_phase_reg, fade_phase_next;
    logic [8:0]  fade_level_reg, fade_level_next;
    rgb_t        levels_reg, levels_next;

    logic [31:0] elapsed;
    logic [31:0] delay;
    logic        due;
    logic        full;
    logic [1:0]  flash_idx;
    logic [2:0]  fade_ph;
    chan_t       fade_chan;
    logic        fade_up;
    logic [7:0]  fade_val;
    logic        fade_write;
    logic [23:0] flash_color;

    assign full    = cfg.speed[10];
    assign elapsed = now - last_event_reg;
    assign due     = elapsed > delay;

    always_comb
    begin
        case (cfg.effect_mode)
            MODE_STROBE: delay = STROBE_TICKS;
            MODE_FLASH:  delay = FLASH_TICKS + (full ? FLASH_EXTRA : 32'd0);
            MODE_FADE:   delay = FADE_TICKS + (full ? FADE_EXTRA : 32'd0);
            default:     delay = 32'd0;
        endcase
    end

    // Flash index wraps before use.
    assign flash_idx = (flash_index_reg >= FLASH_LEN) ? 2'd0 : flash_index_reg;

    always_comb
    begin
        case (flash_idx)
            2'd0:    flash_color = cfg.flash_a;
            2'd1:    flash_color = cfg.flash_b;
            default: flash_color = cfg.flash_c;
        endcase
    end

    // The end of the sixth phase restarts at the red ramp up.
    assign fade_ph = (fade_phase_reg >= FADE_PHASES) ? 3'd0 : fade_phase_reg;

    always_comb
    begin
        case (fade_ph)
            3'd0:    begin fade_chan = CHAN_RED;   fade_up = 1'b1; end
            3'd1:    begin fade_chan = CHAN_BLUE;  fade_up = 1'b0; end
            3'd2:    begin fade_chan = CHAN_GREEN; fade_up = 1'b1; end
            3'd3:    begin fade_chan = CHAN_RED;   fade_up = 1'b0; end
            3'd4:    begin fade_chan = CHAN_BLUE;  fade_up = 1'b1; end
            default: begin fade_chan = CHAN_GREEN; fade_up = 1'b0; end
        endcase
    end

    // The top of a ramp is 256, which the duty saturates to 255.
    assign fade_val   = fade_level_reg[8] ? LEVEL_MAX : fade_level_reg[7:0];
    assign fade_write = fade_up ? (fade_level_reg < FADE_TOP) : (fade_level_reg != 9'd0);

    always_comb
    begin
        last_event_next   = last_event_reg;
        strobe_phase_next = strobe_phase_reg;
        flash_index_next  = flash_index_reg;
        fade_phase_next   = fade_phase_reg;
        fade_level_next   = fade_level_reg;
        levels_next       = levels_reg;
        res.fired         = 1'b0;

        if (!cfg.enable)
        begin
            levels_next = cfg.common_anode ? rgb_t'({3{LEVEL_MAX}}) : rgb_t'(24'd0);
        end
        else
        begin
            case (cfg.effect_mode)
                MODE_STROBE:
                begin
                    if (due)
                    begin
                        res.fired         = 1'b1;
                        last_event_next   = now;
                        strobe_phase_next = !strobe_phase_reg;
                        levels_next       = show_rgb(strobe_phase_reg ? cfg.base_color : 24'd0,
                                                     cfg.common_anode);
                    end
                end
                MODE_FLASH:
                begin
                    if (due)
                    begin
                        res.fired        = 1'b1;
                        last_event_next  = now;
                        levels_next      = show_rgb(flash_color, cfg.common_anode);
                        flash_index_next = flash_idx + 2'd1;
                    end
                end
                MODE_FADE:
                begin
                    if (due)
                    begin
                        res.fired       = 1'b1;
                        last_event_next = now;
                        fade_phase_next = fade_ph;
                        if (fade_write)
                        begin
                            case (fade_chan)
                                CHAN_RED:   levels_next.red   = fade_val;
                                CHAN_GREEN: levels_next.green = fade_val;
                                default:    levels_next.blue  = fade_val;
                            endcase
                            fade_level_next = fade_up ? fade_level_reg + 9'd1
                                                      : fade_level_reg - 9'd1;
                        end
                        else
                        begin
                            fade_phase_next = fade_ph + 3'd1;
                        end
                    end
                end
                default:
                begin
                    levels_next = show_rgb(cfg.base_color, cfg.common_anode);
                end
            endcase
        end
        res.levels = levels_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_event_reg   <= '0;
            strobe_phase_reg <= 1'b0;
            flash_index_reg  <= '0;
            fade_phase_reg   <= '0;
            fade_level_reg   <= '0;
            levels_reg       <= '0;
        end
        else if (mode_clear)
        begin
            strobe_phase_reg <= 1'b0;
            flash_index_reg  <= '0;
            fade_phase_reg   <= '0;
            fade_level_reg   <= '0;
        end
        else if (step_en)
        begin
            last_event_reg   <= last_event_next;
            strobe_phase_reg <= strobe_phase_next;
            flash_index_reg  <= flash_index_next;
            fade_phase_reg   <= fade_phase_next;
            fade_level_reg   <= fade_level_next;
            levels_reg       <= levels_next;
        end
    end

    `RGBLES_ASSERT_IMP(a_fired_needs_timed_mode, res.fired, cfg.enable && cfg.effect_mode != MODE_NORMAL, "step fired outside a timed mode")
    `RGBLES_ASSERT_NXT(a_timer_restarts, step_en && res.fired && !mode_clear, last_event_reg == $past(now), "timer not restarted on a step")
    `RGBLES_ASSERT_IMP(a_fade_phase_range, 1'b1, fade_phase_reg <= FADE_PHASES, "fade phase beyond the last phase")

endmodule

// ===== rtl/core/rgb_led_effect_sequencer_top.sv =====
// Top level of the RGB LED effect sequencer: stream ports, pipeline and register port.
//
// The block takes one timestamp tick per transaction on the slave stream
// (s_tdata = now_ms, in milliseconds, wrapping modulo 2^32) and returns one
// transaction per tick on the master stream carrying the three PWM duties and
// a flag that marks a timed strobe, flash or fade step.
// Configuration sits behind a small APB port with eight 32-bit registers at
// byte addresses 0x00 to 0x1C; pready is always high and a write lands at the
// access phase. The user must change registers only while no tick is in flight;
// the block itself does not enforce this. A tick accepted at a clock edge is held
// in the input register, goes through the effect step logic and, once the output
// register is free, is registered in the output register, which drives m_tvalid.
// The step logic (one 32-bit subtract and compare plus the colour selection) is
// combinational, so one tick can be accepted on every clock while the receiver
// keeps up, one transaction per cycle sustained. When the receiver stalls, the
// output register holds its transaction and the input register can still take
// one more tick; only when both are full does s_tready drop. Reset clears the
// valid flags of both registers, all sequence state and the timer, and loads the
// configuration reset values (strip off, flash colours red, green and blue).
`include "rgb_led_effect_sequencer_top_macros.svh"

module rgb_led_effect_sequencer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbles_pkg::ADDR_W-1:0]   paddr,
    input  logic [rgbles_pkg::DATA_W-1:0]   pwdata,
    output logic [rgbles_pkg::DATA_W-1:0]   prdata,
    output logic                            pready,
    // Tick stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // [31:0] now_ms
    // Duty stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata   // [7:0] red_duty, [15:8] green_duty,
                                                      // [23:16] blue_duty, [24] event_fired
);
    import rgbles_pkg::*;

    cfg_t        cfg;
    logic        mode_clear;
    step_res_t   res;

    logic        in_valid_reg;
    logic [31:0] now_reg;
    logic        out_valid_reg;
    step_res_t   out_data_reg;
    logic        advance;
    logic        step_en;

    rgbles_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .mode_clear (mode_clear)
    );

    rgbles_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .mode_clear (mode_clear),
        .step_en    (step_en),
        .now        (now_reg),
        .res        (res)
    );

    // The output register frees up when it is empty or being taken this cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            now_reg <= s_tdata;
        end
        if (step_en)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg.fired, out_data_reg.levels.blue,
                       out_data_reg.levels.green, out_data_reg.levels.red};

    `RGBLES_ASSERT_IMP(a_stall_only_when_full, !s_tready, in_valid_reg && out_valid_reg && !m_tready, "input stalled with room in the pipeline")
    `RGBLES_ASSERT_NXT(a_step_fills_output, step_en, out_valid_reg, "stepped tick did not reach the output register")
    `RGBLES_ASSERT_NXT(a_held_tick_kept, in_valid_reg && !advance, in_valid_reg && $stable(now_reg), "waiting tick lost or changed")

endmodule

// ===== dv/rgb_duty_checker.sv =====
// Checker for the RGB LED effect sequencer: mirrors the registers, predicts duties, compares.
`timescale 1ns / 100ps

module rgb_duty_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbles_pkg::ADDR_W-1:0]   paddr,
    input  logic [rgbles_pkg::DATA_W-1:0]   pwdata,
    input  logic                            pready,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] now_ms
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [31:0]                     m_tdata,   // [7:0] red, [15:8] green,
                                                       // [23:16] blue, [24] fired
    output int                              fail_count,
    output int                              pending_count
);
    import rgbles_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fired;
    } duty_t;

    // Mirrored configuration.
    logic        enable_r;
    logic        anode_r;
    mode_t       mode_r;
    logic [23:0] base_r;
    logic [10:0] speed_r;
    logic [23:0] flash_col [3];

    // Sequence state and the duties held between ticks.
    logic [31:0] last_mark;
    logic        strobe_dark;
    logic [1:0]  flash_pos;
    logic [2:0]  ramp_phase;
    logic [8:0]  ramp_level;
    rgb_t        held;

    duty_t       duty_q [$];
    duty_t       want;
    int          errors;

    function automatic void paint(input logic [23:0] colour);
        rgb_t c;
        c = colour;
        if (anode_r)
        begin
            c.red   = LEVEL_MAX - c.red;
            c.green = LEVEL_MAX - c.green;
            c.blue  = LEVEL_MAX - c.blue;
        end
        held = c;
    endfunction

    // The elapsed time wraps modulo 2^32 and must strictly exceed the span.
    function automatic logic timer_due(input logic [31:0] now, input logic [31:0] span);
        logic [31:0] waited;
        waited = now - last_mark;
        if (waited > span)
        begin
            last_mark = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Even phases ramp up, odd phases ramp down; levels are never inverted.
    function automatic void ramp_step();
        chan_t      ch;
        logic       rising;
        logic [7:0] lvl;
        if (ramp_phase >= FADE_PHASES)
            ramp_phase = 3'd0;
        rising = ~ramp_phase[0];
        case (ramp_phase)
            3'd0, 3'd3: ch = CHAN_RED;
            3'd1, 3'd4: ch = CHAN_BLUE;
            default:    ch = CHAN_GREEN;
        endcase
        lvl = (ramp_level > 9'd255) ? LEVEL_MAX : ramp_level[7:0];
        if (rising ? (ramp_level < FADE_TOP) : (ramp_level != 9'd0))
        begin
            case (ch)
                CHAN_RED:   held.red   = lvl;
                CHAN_GREEN: held.green = lvl;
                default:    held.blue  = lvl;
            endcase
            ramp_level = rising ? ramp_level + 9'd1 : ramp_level - 9'd1;
        end
        else
            ramp_phase = ramp_phase + 3'd1;
    endfunction

    function automatic duty_t predict_duties(input logic [31:0] now);
        duty_t res;
        logic  full;
        full = (speed_r >= 11'd1024);
        res.fired = 1'b0;
        if (!enable_r)
            held = anode_r ? {3{LEVEL_MAX}} : 24'd0;
        else
        begin
            case (mode_r)
                MODE_STROBE:
                    if (timer_due(now, STROBE_TICKS))
                    begin
                        res.fired = 1'b1;
                        paint(strobe_dark ? base_r : 24'd0);
                        strobe_dark = ~strobe_dark;
                    end
                MODE_FLASH:
                    if (timer_due(now, FLASH_TICKS + (full ? FLASH_EXTRA : 32'd0)))
                    begin
                        res.fired = 1'b1;
                        if (flash_pos >= FLASH_LEN)
                            flash_pos = 2'd0;
                        paint(flash_col[flash_pos]);
                        flash_pos = flash_pos + 2'd1;
                    end
                MODE_FADE:
                    if (timer_due(now, FADE_TICKS + (full ? FADE_EXTRA : 32'd0)))
                    begin
                        res.fired = 1'b1;
                        ramp_step();
                    end
                default:
                    paint(base_r);
            endcase
        end
        res.red   = held.red;
        res.green = held.green;
        res.blue  = held.blue;
        return res;
    endfunction

    function automatic void clear_sequence();
        strobe_dark = 1'b0;
        flash_pos   = 2'd0;
        ramp_phase  = 3'd0;
        ramp_level  = 9'd0;
    endfunction

    function automatic void mirror_write(input reg_idx_t idx, input logic [31:0] word);
        case (idx)
            REG_ENABLE:       enable_r = word[0];
            REG_COMMON_ANODE: anode_r  = word[0];
            REG_EFFECT_MODE:
            begin
                mode_r = mode_t'(word[1:0]);
                clear_sequence();
            end
            REG_BASE_COLOR:   base_r   = word[23:0];
            REG_SPEED:        speed_r  = word[10:0];
            REG_FLASH_A:      flash_col[0] = word[23:0];
            REG_FLASH_B:      flash_col[1] = word[23:0];
            default:          flash_col[2] = word[23:0];
        endcase
    endfunction

    task automatic compare_field(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_r     = 1'b0;
            anode_r      = 1'b0;
            mode_r       = MODE_NORMAL;
            base_r       = 24'd0;
            speed_r      = 11'd0;
            flash_col[0] = 24'hFF0000;
            flash_col[1] = 24'h00FF00;
            flash_col[2] = 24'h0000FF;
            last_mark    = 32'd0;
            held         = 24'd0;
            clear_sequence();
            duty_q.delete();
            errors = 0;
            pending_count <= 0;
            fail_count    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                mirror_write(reg_idx_t'(paddr[4:2]), pwdata);
            if (m_tvalid && m_tready)
            begin
                if (duty_q.size() == 0)
                begin
                    $display("%0t ns: duty transaction with none expected, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = duty_q.pop_front();
                    compare_field("red_duty", want.red, m_tdata[7:0]);
                    compare_field("green_duty", want.green, m_tdata[15:8]);
                    compare_field("blue_duty", want.blue, m_tdata[23:16]);
                    compare_field("event_fired", {7'd0, want.fired}, {7'd0, m_tdata[24]});
                    compare_field("padding", 8'd0, {1'b0, m_tdata[31:25]});
                end
            end
            if (s_tvalid && s_tready)
                duty_q.push_back(predict_duties(s_tdata));
            pending_count <= duty_q.size();
            fail_count    <= errors;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the RGB LED effect sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    import rgbles_pkg::*;

    // The run is cut off here; a correct run needs only a small fraction of it.
    localparam int CYCLE_LIMIT  = 200000;
    // Further cycles allowed after the last expected duty has arrived.
    localparam int DRAIN_CYCLES = 8;
    // The receiver holds off this long, once every HOLD_EVERY of its own cycles.
    localparam int HOLD_EVERY   = 1500;
    localparam int HOLD_CYCLES  = 60;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;

    int                fail_count;
    int                pending_count;
    int                cycle_count;
    logic [31:0]       stamp_ms;    // timestamp of the most recent tick offered
    logic              calm;        // while set, neither side idles at random

    rgb_led_effect_sequencer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] now_ms
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [7:0] red, [15:8] green, [23:16] blue, [24] event_fired
    );

    rgb_duty_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that has not finished by the limit has hung somewhere.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // Duty receiver. It stalls at random with a chance of 38 in a hundred, never while the
    // calm flag is set, and now and then holds off for a long stretch so that the output
    // register and the input register both fill and s_tready has to drop.
    initial
    begin : duty_sink
        int sink_cycles;
        int hold_left;
        sink_cycles = 0;
        hold_left   = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            sink_cycles++;
            if (sink_cycles % HOLD_EVERY == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 38);
        end
    end

    // Register write with a setup and an access phase. Bits above the register's width
    // carry random junk, which the block has to ignore. The bus is left selected so that
    // writes can follow back to back; the next tick releases it.
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value,
                             input int unsigned width);
        logic [31:0] word;
        word = value;
        if (width < 32)
            word = ($urandom << width) | (value & ((32'd1 << width) - 32'd1));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Offer one tick, after a random gap unless the calm flag is set. tvalid stays high
    // after acceptance so that a tick with no gap follows without a bubble.
    task automatic send_tick(input logic [31:0] stamp);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 38)
            gap = $urandom_range(1, 3);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= stamp;
        stamp_ms = stamp;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic tick_after(input logic [31:0] delta);
        send_tick(stamp_ms + delta);
    endtask

    // Stop offering and wait until every tick has had its duty transaction back.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    // Random ticks around the span of the current mode: most land just past it so the
    // timed step fires, some come too early, and the rest jump anywhere in the 32-bit
    // range, which also covers wrap-around and timestamps that go backwards.
    task automatic run_ticks(input int count, input logic [31:0] span, input int fire_pct);
        int          roll;
        logic [31:0] step;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < fire_pct)
                step = span + $urandom_range(1, 4);
            else if (roll < fire_pct + (100 - fire_pct) / 2)
                step = $urandom_range(0, span);
            else
                step = $urandom;
            tick_after(step);
        end
    endtask

    function automatic logic [31:0] pick_colour(input int k);
        case (k % 3)
            0:       return 32'h000000;
            1:       return 32'hFFFFFF;
            default: return $urandom & 32'hFFFFFF;
        endcase
    endfunction

    // One random phase: a full register setting followed by a short burst of ticks.
    // Modes rotate, speed visits zero, just below full, full and the top of its range,
    // and colours alternate between black, white and random values.
    task automatic random_phase(input int k);
        mode_t       mode;
        logic [10:0] spd;
        logic [31:0] span;
        mode = mode_t'(k % 4);
        case (k % 5)
            0:       spd = 11'd0;
            1:       spd = 11'd1023;
            2:       spd = 11'd1024;
            3:       spd = 11'd2047;
            default: spd = 11'($urandom_range(0, 2047));
        endcase
        quiesce();
        reg_write(REG_ENABLE, 32'(k % 6 != 5), 1);
        reg_write(REG_COMMON_ANODE, $urandom_range(1), 1);
        reg_write(REG_EFFECT_MODE, 32'(mode), 2);
        reg_write(REG_BASE_COLOR, pick_colour(k), 24);
        reg_write(REG_SPEED, 32'(spd), 11);
        reg_write(REG_FLASH_A, pick_colour(k + 1), 24);
        reg_write(REG_FLASH_B, pick_colour(k + 2), 24);
        reg_write(REG_FLASH_C, pick_colour(k), 24);
        case (mode)
            MODE_FLASH: span = FLASH_TICKS + ((spd >= 11'd1024) ? FLASH_EXTRA : 32'd0);
            MODE_FADE:  span = FADE_TICKS + ((spd >= 11'd1024) ? FADE_EXTRA : 32'd0);
            default:    span = STROBE_TICKS;
        endcase
        run_ticks(4, span, 70);
    endtask

    initial
    begin
        calm     <= 1'b0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        stamp_ms = 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset the strip is off: the timestamp extremes give black.
        send_tick(32'h0000_0000);
        send_tick(32'hFFFF_FFFF);
        // Still off, but common anode wiring moves the off level to full scale.
        quiesce();
        reg_write(REG_COMMON_ANODE, 1, 1);
        send_tick(32'h5555_5555);
        // Normal mode shows the base colour inverted, then white with the upper byte
        // of the written word ignored.
        quiesce();
        reg_write(REG_ENABLE, 1, 1);
        reg_write(REG_BASE_COLOR, 32'h0012_3456, 24);
        send_tick(32'hAAAA_AAAA);
        quiesce();
        reg_write(REG_COMMON_ANODE, 0, 1);
        reg_write(REG_BASE_COLOR, 32'hFFFF_FFFF, 32);
        send_tick(32'h0000_0000);

        // Strobe: an elapsed time equal to the span does not fire, one more does. The
        // second pair measures across the 32-bit wrap.
        quiesce();
        reg_write(REG_EFFECT_MODE, 32'(MODE_STROBE), 2);
        send_tick(STROBE_TICKS);
        send_tick(STROBE_TICKS + 32'd1);
        send_tick(32'hFFFF_FFFF);
        send_tick(STROBE_TICKS - 32'd1);
        send_tick(STROBE_TICKS);

        // Flash: four steps walk the three colours and wrap back to the first.
        quiesce();
        reg_write(REG_EFFECT_MODE, 32'(MODE_FLASH), 2);
        repeat (4) tick_after(FLASH_TICKS + 32'd1);
        // At full speed the span grows by the extra delay.
        quiesce();
        reg_write(REG_SPEED, 32'd1024, 11);
        tick_after(FLASH_TICKS + FLASH_EXTRA);
        tick_after(32'd1);

        // Fade: speed above full counts as full; then a few normal-speed steps.
        quiesce();
        reg_write(REG_SPEED, 32'd2047, 11);
        reg_write(REG_EFFECT_MODE, 32'(MODE_FADE), 2);
        tick_after(FADE_TICKS + FADE_EXTRA);
        tick_after(32'd1);
        quiesce();
        reg_write(REG_SPEED, 32'd0, 11);
        repeat (2) tick_after(FADE_TICKS + 32'd1);
        // Writing the same mode again restarts the ramp from level zero.
        quiesce();
        reg_write(REG_EFFECT_MODE, 32'(MODE_FADE), 2);
        tick_after(FADE_TICKS + 32'd1);
        // Switching off forces the held duties to the off level, and they stay there
        // after switching back on until the next timed step.
        quiesce();
        reg_write(REG_ENABLE, 0, 1);
        tick_after(32'd1);
        quiesce();
        reg_write(REG_ENABLE, 1, 1);
        tick_after(32'd1);

        // A long fade run. Nearly every tick fires, so the ramp passes through all six
        // phases, including the saturated start of the first ramp down, and wraps back
        // to the first phase. The middle stretch has no random idling on either side.
        quiesce();
        reg_write(REG_EFFECT_MODE, 32'(MODE_FADE), 2);
        run_ticks(300, FADE_TICKS, 96);
        calm <= 1'b1;
        run_ticks(400, FADE_TICKS, 96);
        calm <= 1'b0;
        run_ticks(920, FADE_TICKS, 96);

        // Short phases that sweep the register settings.
        for (int k = 0; k < 12; k++)
            random_phase(k);

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
